>>> sv/art_pkg.sv
// Shared types and constants for the allocation record table.
`timescale 1ns / 1ps

package art_pkg;

	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_DEL   = 2'd1;
	localparam logic [1:0] MODE_PURGE = 2'd2;

	localparam int UNIT_SHIFT = 5;
	localparam int OFS_W      = 15;
	localparam int SIZE_W     = 16;
	localparam int STAMP_W    = 31;
	localparam int OWNER_W    = 8;
	localparam int BOFS_W     = 20;
	localparam int SLOT_W     = 12;
	localparam int FREED_W    = 21;

	// One table entry: free flag, stamp or free link, owner.
	typedef struct packed {
		logic                  free;
		logic [STAMP_W-1:0]    body;
		logic [OWNER_W-1:0]    owner;
	} entry_t;

	typedef struct packed {
		logic                  success;
		logic [SLOT_W-1:0]     slot;
		logic [FREED_W-1:0]    freed;
	} result_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_ADD,
		ST_SCAN,
		ST_DONE
	} seq_state_t;

endpackage

>>> sv/art_mem.sv
// Entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module art_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  art_pkg::entry_t      wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output art_pkg::entry_t      rd_data
);
	import art_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/art_seq.sv
// Sequencer: clearing pass, add, and the read-modify-write removal scan.
`timescale 1ns / 1ps

module art_seq #(
	parameter int SLOTS = 4096,
	parameter int IW    = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     mode,
	input  logic [art_pkg::OWNER_W-1:0]    owner_id,
	input  logic [art_pkg::STAMP_W-1:0]    stamp,
	input  logic [art_pkg::BOFS_W-1:0]     byte_offset,
	output logic                           res_valid,
	input  logic                           res_ready,
	output art_pkg::result_t               res,
	output logic                           wr_en,
	output logic [IW-1:0]                  wr_addr,
	output art_pkg::entry_t                wr_data,
	output logic                           rd_en,
	output logic [IW-1:0]                  rd_addr,
	input  art_pkg::entry_t                rd_data
);
	import art_pkg::*;

	localparam int HW = IW + 1;
	localparam logic [HW-1:0] END_MARK = HW'(SLOTS);
	localparam logic [HW-1:0] LAST_IDX = HW'(SLOTS - 1);

	seq_state_t         state_q, state_d;
	logic [HW-1:0]      head_q, head_d;
	logic [IW-1:0]      last_q, last_d;
	logic [HW-1:0]      cnt_q, cnt_d;
	logic [1:0]         mode_q, mode_d;
	logic [OWNER_W-1:0] owner_q, owner_d;
	logic [STAMP_W-1:0] stamp_q, stamp_d;
	logic [OFS_W-1:0]   ofs_q, ofs_d;
	result_t            res_q, res_d;
	logic               vld_s1, vld_d;
	logic [IW-1:0]      idx_s1, idx_d;

	logic [HW-1:0]      next_link;
	logic [31:0]        last_wide;
	logic [31:0]        head_wide;
	logic               hit;

	assign last_wide = 32'(last_q);
	assign head_wide = 32'(head_q[IW-1:0]);
	assign next_link = (rd_data.body > STAMP_W'(SLOTS)) ? END_MARK : rd_data.body[HW-1:0];
	assign hit = vld_s1 && !rd_data.free && (rd_data.owner == owner_q)
		&& ((mode_q == MODE_PURGE) || (rd_data.body[STAMP_W-1:SIZE_W] == ofs_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			head_q  <= '0;
			last_q  <= '0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			last_q  <= last_d;
			cnt_q   <= cnt_d;
			vld_s1  <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q  <= mode_d;
		owner_q <= owner_d;
		stamp_q <= stamp_d;
		ofs_q   <= ofs_d;
		res_q   <= res_d;
		idx_s1  <= idx_d;
	end

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		last_d    = last_q;
		cnt_d     = cnt_q;
		vld_d     = 1'b0;
		idx_d     = idx_s1;
		mode_d    = mode_q;
		owner_d   = owner_q;
		stamp_d   = stamp_q;
		ofs_d     = ofs_q;
		res_d     = res_q;
		in_stall  = 1'b1;
		res_valid = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = cnt_q[IW-1:0];
		wr_data   = '0;
		rd_en     = 1'b0;
		rd_addr   = cnt_q[IW-1:0];

		case (state_q)
			ST_INIT: begin
				wr_en         = 1'b1;
				wr_data.free  = 1'b1;
				wr_data.body  = STAMP_W'(cnt_q) + STAMP_W'(1);
				wr_data.owner = '0;
				cnt_d         = cnt_q + HW'(1);
				if (cnt_q == LAST_IDX) begin
					cnt_d   = '0;
					head_d  = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					mode_d  = mode;
					owner_d = owner_id;
					stamp_d = stamp;
					ofs_d   = byte_offset[BOFS_W-1:UNIT_SHIFT];
					res_d   = '{success: 1'b0, slot: last_wide[SLOT_W-1:0], freed: '0};
					case (mode)
						MODE_ADD: begin
							if (head_q == END_MARK) begin
								state_d = ST_DONE;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q[IW-1:0];
								state_d = ST_ADD;
							end
						end
						MODE_DEL, MODE_PURGE: begin
							cnt_d   = '0;
							state_d = ST_SCAN;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_ADD: begin
				wr_en         = 1'b1;
				wr_addr       = head_q[IW-1:0];
				wr_data.free  = 1'b0;
				wr_data.body  = stamp_q;
				wr_data.owner = owner_q;
				last_d        = head_q[IW-1:0];
				head_d        = next_link;
				res_d         = '{success: 1'b1, slot: head_wide[SLOT_W-1:0], freed: '0};
				state_d       = ST_DONE;
			end
			ST_SCAN: begin
				if (cnt_q != END_MARK) begin
					rd_en   = 1'b1;
					rd_addr = cnt_q[IW-1:0];
					cnt_d   = cnt_q + HW'(1);
					vld_d   = 1'b1;
					idx_d   = cnt_q[IW-1:0];
				end
				if (hit) begin
					wr_en         = 1'b1;
					wr_addr       = idx_s1;
					wr_data.free  = 1'b1;
					wr_data.body  = STAMP_W'(head_q);
					wr_data.owner = rd_data.owner;
					head_d        = {1'b0, idx_s1};
					if (mode_q == MODE_DEL) begin
						res_d = '{success: 1'b1, slot: last_wide[SLOT_W-1:0],
							freed: {rd_data.body[SIZE_W-1:0], {UNIT_SHIFT{1'b0}}}};
						vld_d   = 1'b0;
						state_d = ST_DONE;
					end
				end
				if (!vld_s1 && (cnt_q == END_MARK)) begin
					res_d = '{success: (mode_q == MODE_PURGE),
						slot: last_wide[SLOT_W-1:0], freed: '0};
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res = res_q;

endmodule

>>> sv/allocation_record_table.sv
// Allocation record table top level: sequencer, entry memory, output register.
`timescale 1ns / 1ps
//
// Keeps SLOTS allocation records (owner id, offset and size in 32-byte units)
// with free slots on a linked free list held in the entry memory.
// Input channel: in_valid/in_stall with mode, owner_id, stamp, byte_offset.
// Output channel: out_valid/out_stall with success, slot, freed_bytes; one
// result beat for every input beat, in order.
// An add passes through the add and done states to the output register; an
// unused mode or an add on a full table goes straight to the done state.
// Removals scan the memory one entry per cycle through its single read port,
// stopping early when a remove by offset hits. One item is in work at a time;
// the next beat is taken at the earliest in the cycle after the result moves
// to the output register.
// After reset the block runs a clearing pass over all SLOTS entries that builds
// the free list; in_stall stays high during it.
// The output register holds a result while out_stall is high; a new input
// beat is still taken meanwhile, and its result waits in the sequencer until
// the output register frees up.

module allocation_record_table #(
	parameter int SLOTS = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    mode,
	input  logic [art_pkg::OWNER_W-1:0]   owner_id,
	input  logic [art_pkg::STAMP_W-1:0]   stamp,
	input  logic [art_pkg::BOFS_W-1:0]    byte_offset,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          success,
	output logic [art_pkg::SLOT_W-1:0]    slot,
	output logic [art_pkg::FREED_W-1:0]   freed_bytes
);
	import art_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic          res_valid;
	logic          res_ready;
	result_t       res;
	result_t       out_q;
	logic          out_valid_q;

	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	entry_t        rd_data;

	art_seq #(
		.SLOTS(SLOTS),
		.IW   (IW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.owner_id   (owner_id),
		.stamp      (stamp),
		.byte_offset(byte_offset),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	art_mem #(
		.DEPTH(SLOTS),
		.AW   (IW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign success     = out_q.success;
	assign slot        = out_q.slot;
	assign freed_bytes = out_q.freed;

endmodule

>>> tb/sv/tb_allocation_record_table.sv
// Testbench for the allocation record table: directed table, removal bursts, random traffic.
`timescale 1ns / 1ps

module tb_allocation_record_table;
	import art_pkg::*;

	localparam int SLOTS = 4096;
	localparam int RAND_ITEMS = 100;
	localparam int QUIET_ITEMS = 30;
	localparam int DIRECTED_N = 23;
	localparam int HOLD_CYCLES = 3 * SLOTS;
	localparam int WATCHDOG = 16 * SLOTS;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic [OWNER_W-1:0] owner;
		logic [STAMP_W-1:0] stamp;
		logic [BOFS_W-1:0]  bofs;
	} req_t;

	typedef struct packed {
		req_t    req;
		bit      chk;
		result_t want;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          mode;
	logic [OWNER_W-1:0]  owner_id;
	logic [STAMP_W-1:0]  stamp;
	logic [BOFS_W-1:0]   byte_offset;
	logic                out_valid;
	logic                out_stall;
	logic                success;
	logic [SLOT_W-1:0]   slot;
	logic [FREED_W-1:0]  freed_bytes;

	// shadow copy of the table
	logic [31:0]         rec_word [SLOTS];
	logic [OWNER_W-1:0]  rec_owner [SLOTS];
	int                  free_head;
	int                  last_slot;

	result_t             pending_results [$];
	result_t             seen;
	result_t             want_now;
	row_t                plan [DIRECTED_N];

	int beats_in, beats_out, mismatches, idle_cycles;
	int n_adds, n_full, n_dels, n_hits, n_purges, n_unused;
	bit quiet, held;

	allocation_record_table #(.SLOTS(SLOTS)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.owner_id    (owner_id),
		.stamp       (stamp),
		.byte_offset (byte_offset),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.success     (success),
		.slot        (slot),
		.freed_bytes (freed_bytes)
	);

	always #2 clk = ~clk;

	function automatic result_t track_records(req_t r);
		result_t res;
		int      nxt;
		int      i;
		res = '0;
		case (r.mode)
			MODE_ADD: begin
				n_adds++;
				if (free_head < SLOTS) begin
					nxt = int'(rec_word[free_head][30:0]);
					if (nxt > SLOTS)
						nxt = SLOTS;
					last_slot = free_head;
					free_head = nxt;
					rec_word[last_slot] = {1'b0, r.stamp};
					rec_owner[last_slot] = r.owner;
					res.success = 1'b1;
				end else begin
					n_full++;
				end
			end
			MODE_DEL: begin
				n_dels++;
				for (i = 0; i < SLOTS; i++) begin
					if (!rec_word[i][31] && rec_word[i][30:16] == r.bofs[19:5]
							&& rec_owner[i] == r.owner) begin
						res.freed = {rec_word[i][SIZE_W-1:0], 5'b0};
						rec_word[i] = {1'b1, 31'(free_head)};
						free_head = i;
						res.success = 1'b1;
						n_hits++;
						break;
					end
				end
			end
			MODE_PURGE: begin
				n_purges++;
				for (i = 0; i < SLOTS; i++) begin
					if (!rec_word[i][31] && rec_owner[i] == r.owner) begin
						rec_word[i] = {1'b1, 31'(free_head)};
						free_head = i;
					end
				end
				res.success = 1'b1;
			end
			default: n_unused++;
		endcase
		res.slot = last_slot[SLOT_W-1:0];
		return res;
	endfunction

	function automatic int find_used(int from);
		int k;
		for (k = 0; k < SLOTS; k++)
			if (!rec_word[(from + k) % SLOTS][31])
				return (from + k) % SLOTS;
		return -1;
	endfunction

	// adds use few owners and offsets so removals collide; removals mostly hit live records
	function automatic req_t make_request(int add_pct);
		req_t r;
		int   at;
		int   pick;
		r.mode = MODE_ADD;
		r.stamp = 31'($urandom);
		if ($urandom_range(0, 3) != 0)
			r.stamp[30:16] = 15'($urandom_range(0, 3));
		r.owner = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
		r.bofs = 20'($urandom);
		if ($urandom_range(0, 99) < add_pct)
			return r;
		at = find_used($urandom_range(0, SLOTS - 1));
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			r.mode = MODE_DEL;
			if (at >= 0) begin
				r.owner = rec_owner[at];
				r.bofs = {rec_word[at][30:16], 5'($urandom)};
			end
		end else if (pick < 62) begin
			r.mode = MODE_DEL;
		end else if (pick < 92) begin
			r.mode = MODE_PURGE;
			if (pick < 85 && at >= 0)
				r.owner = rec_owner[at];
		end else begin
			r.mode = MODE_UNUSED;
		end
		return r;
	endfunction

	task automatic push_request(input req_t r, input bit chk, input result_t want);
		result_t got;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= r.mode;
		owner_id <= r.owner;
		stamp <= r.stamp;
		byte_offset <= r.bofs;
		do @(posedge clk); while (in_stall !== 1'b0);
		got = track_records(r);
		pending_results.push_back(chk ? want : got);
		beats_in++;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int   i;
		req_t r;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_ADD;
		owner_id = '0;
		stamp = '0;
		byte_offset = '0;
		for (i = 0; i < SLOTS; i++) begin
			rec_word[i] = {1'b1, 31'(i + 1)};
			rec_owner[i] = '0;
		end
		free_head = 0;
		last_slot = 0;

		//            mode         owner  stamp          bofs         chk   success slot    freed
		plan[0]  = {MODE_ADD,    8'h00, 31'h0000_0000, 20'h00000, 1'b1, 1'b1, 12'd0, 21'h0};
		plan[1]  = {MODE_ADD,    8'hFF, 31'h7FFF_FFFF, 20'h00000, 1'b1, 1'b1, 12'd1, 21'h0};
		plan[2]  = {MODE_ADD,    8'hA5, 31'h2AAA_5555, 20'h00000, 1'b1, 1'b1, 12'd2, 21'h0};
		plan[3]  = {MODE_DEL,    8'hFF, 31'h0000_0000, 20'hFFFFF, 1'b1, 1'b1, 12'd2, 21'h1FFFE0};
		plan[4]  = {MODE_DEL,    8'hA5, 31'h0000_0000, 20'h5555F, 1'b1, 1'b1, 12'd2, 21'h0AAAA0};
		plan[5]  = {MODE_ADD,    8'h01, 31'h0001_0002, 20'h00000, 1'b1, 1'b1, 12'd2, 21'h0};
		plan[6]  = {MODE_DEL,    8'h07, 31'h0000_0000, 20'h00000, 1'b1, 1'b0, 12'd2, 21'h0};
		plan[7]  = {MODE_DEL,    8'h01, 31'h0000_0000, 20'h00000, 1'b1, 1'b0, 12'd2, 21'h0};
		plan[8]  = {MODE_UNUSED, 8'hFF, 31'h7FFF_FFFF, 20'hFFFFF, 1'b1, 1'b0, 12'd2, 21'h0};
		plan[9]  = {MODE_PURGE,  8'h00, 31'h0000_0000, 20'h00000, 1'b1, 1'b1, 12'd2, 21'h0};
		plan[10] = {MODE_PURGE,  8'h00, 31'h0000_0000, 20'h00000, 1'b1, 1'b1, 12'd2, 21'h0};
		plan[11] = {MODE_ADD,    8'h09, 31'h0003_000A, 20'h00000, 1'b0, 34'h0};
		plan[12] = {MODE_ADD,    8'h09, 31'h0003_0014, 20'h00000, 1'b0, 34'h0};
		plan[13] = {MODE_ADD,    8'h09, 31'h0003_001E, 20'h00000, 1'b0, 34'h0};
		plan[14] = {MODE_ADD,    8'h0A, 31'h0003_0028, 20'h00000, 1'b0, 34'h0};
		plan[15] = {MODE_DEL,    8'h09, 31'h0000_0000, 20'h00060, 1'b0, 34'h0};
		plan[16] = {MODE_DEL,    8'h09, 31'h0000_0000, 20'h0007F, 1'b0, 34'h0};
		plan[17] = {MODE_ADD,    8'h09, 31'h0003_FFFF, 20'h00000, 1'b0, 34'h0};
		plan[18] = {MODE_PURGE,  8'h09, 31'h0000_0000, 20'h00000, 1'b0, 34'h0};
		plan[19] = {MODE_DEL,    8'h0A, 31'h0000_0000, 20'h00060, 1'b0, 34'h0};
		plan[20] = {MODE_ADD,    8'h80, 31'h4000_0000, 20'h00000, 1'b0, 34'h0};
		plan[21] = {MODE_UNUSED, 8'h00, 31'h0000_0000, 20'h00000, 1'b0, 34'h0};
		plan[22] = {MODE_PURGE,  8'hFF, 31'h7FFF_FFFF, 20'hFFFFF, 1'b0, 34'h0};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIRECTED_N; i++)
			push_request(plan[i].req, plan[i].chk, plan[i].want);

		// a few adds, a run of removals, then a purge of each common owner
		repeat (3) push_request(make_request(100), 1'b0, '0);
		repeat (6) push_request(make_request(0), 1'b0, '0);
		for (i = 0; i < 8; i++) begin
			r = make_request(0);
			r.mode = MODE_PURGE;
			r.owner = 8'(i);
			push_request(r, 1'b0, '0);
		end

		for (i = 0; i < RAND_ITEMS; i++) begin
			quiet = (i >= RAND_ITEMS - QUIET_ITEMS);
			push_request(make_request(45), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 16) @(posedge clk);
		mismatches += pending_results.size();

		$display("%0d beats in, %0d out: %0d adds (%0d refused on a full table), %0d removes",
			beats_in, beats_out, n_adds, n_full, n_dels);
		$display("  (%0d hits), %0d owner purges, %0d unused-mode beats, %0d mismatches",
			n_hits, n_purges, n_unused, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// receiver: random stall bursts, one long hold-off while the sender keeps going
	initial begin : receiver
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && !held && beats_out >= 40) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			beats_out++;
			seen = {success, slot, freed_bytes};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %0d: success %0b slot %0d freed %0d",
						beats_out, seen.success, seen.slot, seen.freed);
			end else begin
				want_now = pending_results.pop_front();
				if (seen !== want_now) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result beat %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d",
							beats_out, want_now.success, want_now.slot, want_now.freed,
							seen.success, seen.slot, seen.freed);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				idle_cycles, pending_results.size());
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
